// File: src/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies; imported by every module of the block.
package uer_pkg;

  localparam int unsigned TW_W       = 8;   // trigger width register
  localparam int unsigned GAP_W      = 17;  // post-echo gap register
  localparam int unsigned CFG_W      = 17;  // widest register
  localparam int unsigned CNT_W      = 17;  // tick counter
  localparam int unsigned ECHO_W     = 16;  // echo width counter
  localparam int unsigned SMP_W      = 3;   // samples done
  localparam int unsigned SUM_W      = 19;  // width accumulator
  localparam int unsigned DIST_W     = 15;  // distance output
  localparam int unsigned DIST_SHIFT = 4;   // result in 1/16 cm
  localparam int unsigned SOUND_DIV  = 58;  // us of round trip per cm

  localparam logic [TW_W-1:0]  TRIG_WIDTH_RST = 8'd20;
  localparam logic [GAP_W-1:0] GAP_RST        = 17'd50000;

  typedef enum logic {
    CFG_TRIG_WIDTH = 1'b0,
    CFG_GAP        = 1'b1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_TRIG = 5'b00010,
    PH_WAIT = 5'b00100,
    PH_MEAS = 5'b01000,
    PH_GAP  = 5'b10000
  } phase_e;

  // one result item
  typedef struct packed {
    logic              trig;
    logic              busy;
    logic              done;
    logic [DIST_W-1:0] dist_val;
  } res_t;

  // accumulator view handed to the distance unit
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             wr;
  } sum_t;

endpackage

// File: src/uer_dist.sv
// Distance unit: sum*16/(58*SAMPLE_COUNT) by reciprocal multiplication, registered.
// Depends on uer_pkg.
module uer_dist import uer_pkg::*; #(
  parameter int unsigned SAMPLE_COUNT = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sum_t              sum_i,
  output logic [DIST_W-1:0] quot_o,
  output logic              stale_o
);

  localparam int unsigned DEN    = SOUND_DIV * SAMPLE_COUNT;
  localparam int unsigned X_W    = SUM_W + DIST_SHIFT;
  localparam int unsigned L      = $clog2(DEN);
  localparam int unsigned SH     = X_W + L;
  localparam int unsigned M_W    = X_W + 1;
  localparam int unsigned PROD_W = X_W + M_W;
  // m = ceil(2^SH / DEN), exact for every X_W-bit dividend
  localparam logic [63:0] MUL = ((64'd1 << SH) + 64'(DEN) - 64'd1) / 64'(DEN);

  logic [X_W-1:0]    x;
  logic [PROD_W-1:0] prod;
  logic [DIST_W-1:0] quot_q;
  logic              stale_q;

  assign x    = {sum_i.sum, {DIST_SHIFT{1'b0}}};
  assign prod = PROD_W'(x) * PROD_W'(MUL[M_W-1:0]);

  always_ff @(posedge clk_i) begin
    quot_q <= prod[SH +: DIST_W];
  end

  // the quotient is registered from the accumulator, so it is stale in the cycle after a write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stale_q <= 1'b0;
    end else begin
      stale_q <= sum_i.wr;
    end
  end

  assign quot_o  = quot_q;
  assign stale_o = stale_q;

endmodule

// File: src/uer_ctrl.sv
// Ranging sequencer: trigger, echo wait, echo count, gap and averaging state.
// Depends on uer_pkg.
module uer_ctrl import uer_pkg::*; #(
  parameter int unsigned SAMPLE_COUNT = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              start_i,
  input  logic              echo_i,
  input  logic [TW_W-1:0]   trig_width_i,
  input  logic [GAP_W-1:0]  gap_i,
  input  logic [DIST_W-1:0] quot_i,
  output res_t              res_o,
  output sum_t              sum_o,
  output logic              done_pend_o
);

  phase_e             phase_q, phase_d;
  logic [CNT_W-1:0]   tick_q, tick_d, tick_inc;
  logic [ECHO_W-1:0]  echo_q, echo_d;
  logic [SMP_W-1:0]   smp_q, smp_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [DIST_W-1:0]  last_q, last_d;
  logic               trig, done, sum_wr, gap_end, short_trig;

  assign tick_inc   = tick_q + CNT_W'(1);
  assign gap_end    = tick_q >= CNT_W'(gap_i);
  assign short_trig = trig_width_i <= TW_W'(1);
  assign done_pend_o = (phase_q == PH_GAP) && gap_end
                       && (smp_q >= SMP_W'(SAMPLE_COUNT));

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    echo_d  = echo_q;
    smp_d   = smp_q;
    sum_d   = sum_q;
    last_d  = last_q;
    trig    = 1'b0;
    done    = 1'b0;
    sum_wr  = 1'b0;
    unique case (phase_q)
      PH_TRIG: begin
        trig   = 1'b1;
        tick_d = tick_inc;
        if (tick_inc >= CNT_W'(trig_width_i)) phase_d = PH_WAIT;
      end
      PH_WAIT: begin
        if (echo_i) begin
          echo_d  = ECHO_W'(1);
          phase_d = PH_MEAS;
        end
      end
      PH_MEAS: begin
        if (echo_i) begin
          if (echo_q != '1) echo_d = echo_q + ECHO_W'(1);
        end else begin
          sum_d   = sum_q + SUM_W'(echo_q);
          sum_wr  = 1'b1;
          smp_d   = smp_q + SMP_W'(1);
          tick_d  = '0;
          phase_d = PH_GAP;
        end
      end
      PH_GAP: begin
        if (!gap_end) begin
          tick_d = tick_inc;
        end else if (done_pend_o) begin
          last_d  = quot_i;
          done    = 1'b1;
          phase_d = PH_IDLE;
        end else begin
          trig    = 1'b1;
          tick_d  = CNT_W'(1);
          phase_d = short_trig ? PH_WAIT : PH_TRIG;
        end
      end
      default: begin
        // idle, and any code that is not a legal phase
        phase_d = PH_IDLE;
        if (start_i) begin
          smp_d   = '0;
          sum_d   = '0;
          sum_wr  = 1'b1;
          echo_d  = '0;
          trig    = 1'b1;
          tick_d  = CNT_W'(1);
          phase_d = short_trig ? PH_WAIT : PH_TRIG;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      echo_q  <= '0;
      smp_q   <= '0;
      sum_q   <= '0;
      last_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      echo_q  <= echo_d;
      smp_q   <= smp_d;
      sum_q   <= sum_d;
      last_q  <= last_d;
    end
  end

  assign res_o.trig     = trig;
  assign res_o.busy     = phase_d != PH_IDLE;
  assign res_o.done     = done;
  assign res_o.dist_val = last_d;

  assign sum_o.sum = sum_q;
  assign sum_o.wr  = sum_wr && step_i;

endmodule

// File: src/ultrasonic_echo_ranger_unit.sv
// Ultrasonic echo ranger, top level: handshake registers, config registers, assertions.
// Depends on uer_pkg, uer_ctrl, uer_dist.
//
// Each input item is one microsecond tick (start request, sampled echo level) and yields
// one result item (trigger level, busy, done, distance in 1/16 cm). Items enter an input
// register and the result is formed combinationally into an output register, so the
// block takes one item per clock while results are taken; each result passes the input
// register and then the output register. One exception: when the done tick is the item
// directly after the one that closed the last echo (zero gap), it is held while the
// registered distance quotient is stale. The result register is refilled while the
// previous result is taken. Configuration writes apply from the next item processed.
module ultrasonic_echo_ranger_unit import uer_pkg::*; #(
  parameter int unsigned SAMPLE_COUNT = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              start_req_i,
  input  logic              echo_level_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              trigger_level_o,
  output logic              busy_res_o,
  output logic              done_res_o,
  output logic [DIST_W-1:0] distance_sixteenths_cm_o
);

  logic              in_valid_q, start_q, echo_q;
  logic              out_valid_q;
  res_t              res, res_q;
  sum_t              sum;
  logic [DIST_W-1:0] quot;
  logic              stale, done_pend, advance;
  logic [TW_W-1:0]   trig_width_q;
  logic [GAP_W-1:0]  gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_width_q <= TRIG_WIDTH_RST;
      gap_q        <= GAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TRIG_WIDTH: trig_width_q <= cfg_wdata_i[TW_W-1:0];
        CFG_GAP:        gap_q        <= cfg_wdata_i[GAP_W-1:0];
      endcase
    end
  end

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i) && !(done_pend && stale);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      start_q <= start_req_i;
      echo_q  <= echo_level_i;
    end
  end

  uer_ctrl #(
    .SAMPLE_COUNT(SAMPLE_COUNT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .start_i     (start_q),
    .echo_i      (echo_q),
    .trig_width_i(trig_width_q),
    .gap_i       (gap_q),
    .quot_i      (quot),
    .res_o       (res),
    .sum_o       (sum),
    .done_pend_o (done_pend)
  );

  uer_dist #(
    .SAMPLE_COUNT(SAMPLE_COUNT)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sum_i  (sum),
    .quot_o (quot),
    .stale_o(stale)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res;
  end

  assign out_valid_o              = out_valid_q;
  assign trigger_level_o          = res_q.trig;
  assign busy_res_o               = res_q.busy;
  assign done_res_o               = res_q.done;
  assign distance_sixteenths_cm_o = res_q.dist_val;

  // a finished run is never still busy and never drives the trigger
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o && !trigger_level_o)
    else $error("done item while busy or triggering");

  // trigger ticks always belong to a run
  a_trig_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && trigger_level_o |-> busy_res_o)
    else $error("trigger driven outside a run");

  // an item held in the input register is not dropped
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("input item lost");

  // distance changes between results only with a done item
  a_dist_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !res.done |=> $stable(u_ctrl.last_q))
    else $error("distance changed without done");

endmodule
